// ===== design/sam_pkg.sv =====
// Shared types, widths, codes and reset values for the stepper axis core.
// No dependencies; every other design file refers to it by scoped names.
package sam_pkg;

    localparam int CMD_W    = 2;
    localparam int DIST_W   = 12;
    localparam int COIL_W   = 4;
    localparam int POS_W    = 24;
    localparam int STEPS_W  = 24;
    localparam int TICK_W   = 16;
    localparam int SEQ_W    = 3;
    localparam int PERIOD_W = 16;
    localparam int SCALE_W  = 16;
    localparam int BACK_W   = 16;
    localparam int THRESH_W = 20;
    localparam int TARGET_W = DIST_W + SCALE_W;
    localparam int FRAC_W   = 8;
    localparam int DIFF_W   = POS_W + FRAC_W + 2;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam logic [PERIOD_W-1:0] RST_STEP_PERIOD = PERIOD_W'(800);
    localparam logic [SCALE_W-1:0]  RST_SCALE_Q8    = SCALE_W'(10476);
    localparam logic [BACK_W-1:0]   RST_BACKOFF     = BACK_W'(782);
    localparam logic [THRESH_W-1:0] RST_REV_THRESH  = THRESH_W'(18413);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_MOVE  = 2'd1,
        CMD_HOME  = 2'd2,
        CMD_LIMIT = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_STEP_PERIOD = 2'd0,
        REG_SCALE_Q8    = 2'd1,
        REG_BACKOFF     = 2'd2,
        REG_REV_THRESH  = 2'd3
    } t_reg;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_MOVE = 4'b0010,
        PH_SEEK = 4'b0100,
        PH_BACK = 4'b1000
    } t_phase;

    // Half-step coil pattern for each sequence index.
    function automatic logic [COIL_W-1:0] coil_pattern(input logic [SEQ_W-1:0] idx);
        logic [COIL_W-1:0] pat;
        case (idx)
            3'd0:    pat = 4'h1;
            3'd1:    pat = 4'h3;
            3'd2:    pat = 4'h2;
            3'd3:    pat = 4'h6;
            3'd4:    pat = 4'h4;
            3'd5:    pat = 4'hC;
            3'd6:    pat = 4'h8;
            3'd7:    pat = 4'h9;
            default: pat = 4'h0;
        endcase
        return pat;
    endfunction

endpackage

// ===== design/sam_ifs.sv =====
// Valid/ready stream interfaces for the command input and the result output.
// Depends on sam_pkg for the field widths.
interface sam_in_if;
    logic                         valid;
    logic                         ready;
    logic [sam_pkg::CMD_W-1:0]    command;
    logic [sam_pkg::DIST_W-1:0]   distance;

    modport source (output valid, output command, output distance, input ready);
    modport sink   (input valid, input command, input distance, output ready);
endinterface

interface sam_out_if;
    logic                                valid;
    logic                                ready;
    logic [sam_pkg::COIL_W-1:0]          coils;
    logic signed [sam_pkg::POS_W-1:0]    position;
    logic                                busy_res;
    logic                                done_res;

    modport source (output valid, output coils, output position, output busy_res,
                    output done_res, input ready);
    modport sink   (input valid, input coils, input position, input busy_res,
                    input done_res, output ready);
endinterface

// ===== design/stepper_axis_move_and_home_core.sv =====
// Half-step stepper axis controller with move-to and homing, single axis.
// Depends on sam_pkg and on the stream interfaces in sam_ifs.sv.
//
// The core takes one command transfer per clock cycle and returns exactly one
// result transfer for each, in order. An item passes through two registers: an
// input stage, where the distance is multiplied by the Q8.8 scale factor, and
// the result stage, where the axis state is updated and the result is
// captured. A tick counts one microsecond of time; moves, home requests and
// limit events do not. The input side keeps accepting while a result waits in
// the output register; it stalls only when both stages hold items and the
// output is not taken. Configuration registers are written over the APB port
// at byte addresses 0, 4, 8 and 12 (step period, scale, backoff count, reverse
// threshold) and must only be written while no transfer is in flight. Coils
// are driven off whenever the axis is idle.
module stepper_axis_move_and_home_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    sam_in_if.sink                         i_cmd,
    sam_out_if.source                      o_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sam_pkg::PADDR_W-1:0]    paddr,
    input  logic [sam_pkg::PDATA_W-1:0]    pwdata,
    output logic [sam_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);

    // Configuration registers.
    logic [sam_pkg::PERIOD_W-1:0] r_step_period;
    logic [sam_pkg::SCALE_W-1:0]  r_scale_q8;
    logic [sam_pkg::BACK_W-1:0]   r_backoff;
    logic [sam_pkg::THRESH_W-1:0] r_rev_thresh;

    // Input stage.
    logic                          r_in_vld;
    sam_pkg::t_cmd                 r_cmd;
    logic [sam_pkg::TARGET_W-1:0]  r_target;

    // Axis state.
    sam_pkg::t_phase               r_phase, n_phase;
    logic [sam_pkg::POS_W-1:0]     r_pos, n_pos;
    logic [sam_pkg::STEPS_W-1:0]   r_steps_left, n_steps_left;
    logic                          r_dir_neg, n_dir_neg;
    logic [sam_pkg::SEQ_W-1:0]     r_seq_idx, n_seq_idx;
    logic [sam_pkg::TICK_W-1:0]    r_elapsed, n_elapsed;
    logic                          r_zero_after, n_zero_after;
    logic                          n_done;

    // Result stage.
    logic                          r_out_vld;
    logic [sam_pkg::COIL_W-1:0]    r_coils;
    logic [sam_pkg::POS_W-1:0]     r_position;
    logic                          r_busy;
    logic                          r_done;

    logic                          w_out_free;
    logic                          w_adv;
    logic                          w_cfg_wr;

    // Move-to arithmetic: signed distance in 1/256 steps, then ceiling of its
    // magnitude in whole steps, saturated to the step counter width.
    logic signed [sam_pkg::DIFF_W-1:0]   w_diff;
    logic        [sam_pkg::DIFF_W-1:0]   w_diff_neg;
    logic        [sam_pkg::DIFF_W-2:0]   w_mag;
    logic        [sam_pkg::STEPS_W:0]    w_ceil;
    logic        [sam_pkg::STEPS_W-1:0]  w_move_steps;
    logic                                w_past_thresh;

    assign w_out_free  = !r_out_vld || o_res.ready;
    assign w_adv       = r_in_vld && w_out_free;
    assign i_cmd.ready = !r_in_vld || w_out_free;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (sam_pkg::t_reg'(paddr[3:2]))
            sam_pkg::REG_STEP_PERIOD: prdata = sam_pkg::PDATA_W'(r_step_period);
            sam_pkg::REG_SCALE_Q8:    prdata = sam_pkg::PDATA_W'(r_scale_q8);
            sam_pkg::REG_BACKOFF:     prdata = sam_pkg::PDATA_W'(r_backoff);
            sam_pkg::REG_REV_THRESH:  prdata = sam_pkg::PDATA_W'(r_rev_thresh);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_period <= sam_pkg::RST_STEP_PERIOD;
            r_scale_q8    <= sam_pkg::RST_SCALE_Q8;
            r_backoff     <= sam_pkg::RST_BACKOFF;
            r_rev_thresh  <= sam_pkg::RST_REV_THRESH;
        end else if (w_cfg_wr) begin
            case (sam_pkg::t_reg'(paddr[3:2]))
                sam_pkg::REG_STEP_PERIOD: r_step_period <= pwdata[sam_pkg::PERIOD_W-1:0];
                sam_pkg::REG_SCALE_Q8:    r_scale_q8    <= pwdata[sam_pkg::SCALE_W-1:0];
                sam_pkg::REG_BACKOFF:     r_backoff     <= pwdata[sam_pkg::BACK_W-1:0];
                sam_pkg::REG_REV_THRESH:  r_rev_thresh  <= pwdata[sam_pkg::THRESH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The input stage also forms the move target, distance times scale, so
    // the multiplier output is registered in the target register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_vld <= i_cmd.valid;
        end
        if (i_cmd.valid && i_cmd.ready) begin
            r_cmd    <= sam_pkg::t_cmd'(i_cmd.command);
            r_target <= sam_pkg::TARGET_W'(i_cmd.distance) * sam_pkg::TARGET_W'(r_scale_q8);
        end
    end

    always_comb begin
        w_diff = $signed({{(sam_pkg::DIFF_W - sam_pkg::TARGET_W){1'b0}}, r_target})
               - $signed({{2{r_pos[sam_pkg::POS_W-1]}}, r_pos, {sam_pkg::FRAC_W{1'b0}}});
        w_diff_neg = -w_diff;
        w_mag  = w_diff[sam_pkg::DIFF_W-1] ? w_diff_neg[sam_pkg::DIFF_W-2:0]
                                           : w_diff[sam_pkg::DIFF_W-2:0];
        w_ceil = w_mag[sam_pkg::DIFF_W-2:sam_pkg::FRAC_W]
               + (sam_pkg::STEPS_W + 1)'(|w_mag[sam_pkg::FRAC_W-1:0]);
        w_move_steps = w_ceil[sam_pkg::STEPS_W] ? '1 : w_ceil[sam_pkg::STEPS_W-1:0];
        w_past_thresh = $signed({r_pos[sam_pkg::POS_W-1], r_pos})
                      > $signed({{(sam_pkg::POS_W + 1 - sam_pkg::THRESH_W){1'b0}},
                                 r_rev_thresh});
    end

    // Next axis state for the item held in the input stage.
    always_comb begin
        logic [sam_pkg::TICK_W-1:0]  tick_inc;
        logic [sam_pkg::STEPS_W-1:0] steps_dec;
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_steps_left = r_steps_left;
        n_dir_neg    = r_dir_neg;
        n_seq_idx    = r_seq_idx;
        n_elapsed    = r_elapsed;
        n_zero_after = r_zero_after;
        n_done       = 1'b0;
        tick_inc     = (r_elapsed != '1) ? r_elapsed + 1'b1 : r_elapsed;
        steps_dec    = (r_steps_left != '0) ? r_steps_left - 1'b1 : r_steps_left;
        case (r_cmd)
            sam_pkg::CMD_TICK: begin
                n_elapsed = tick_inc;
                if (r_phase != sam_pkg::PH_IDLE && tick_inc >= r_step_period) begin
                    n_elapsed = '0;
                    n_seq_idx = r_dir_neg ? r_seq_idx - 1'b1 : r_seq_idx + 1'b1;
                    n_pos     = r_dir_neg ? r_pos - 1'b1 : r_pos + 1'b1;
                    if (r_phase == sam_pkg::PH_MOVE || r_phase == sam_pkg::PH_BACK) begin
                        n_steps_left = steps_dec;
                        if (steps_dec == '0) begin
                            n_phase = sam_pkg::PH_IDLE;
                            n_done  = 1'b1;
                            if (r_phase == sam_pkg::PH_BACK) begin
                                n_zero_after = 1'b0;
                                if (r_zero_after) begin
                                    n_pos = '0;
                                end
                            end
                        end
                    end
                end
            end
            sam_pkg::CMD_MOVE: begin
                if (r_phase == sam_pkg::PH_IDLE || r_phase == sam_pkg::PH_MOVE) begin
                    n_dir_neg    = w_diff[sam_pkg::DIFF_W-1];
                    n_steps_left = w_move_steps;
                    if (w_move_steps == '0) begin
                        n_phase = sam_pkg::PH_IDLE;
                        n_done  = 1'b1;
                    end else begin
                        n_phase = sam_pkg::PH_MOVE;
                    end
                end
            end
            sam_pkg::CMD_HOME: begin
                if (r_phase == sam_pkg::PH_IDLE || r_phase == sam_pkg::PH_MOVE) begin
                    n_phase      = sam_pkg::PH_SEEK;
                    n_dir_neg    = 1'b1;
                    n_steps_left = '0;
                end
            end
            sam_pkg::CMD_LIMIT: begin
                if (r_phase != sam_pkg::PH_BACK) begin
                    n_dir_neg    = w_past_thresh;
                    n_steps_left = sam_pkg::STEPS_W'(r_backoff);
                    n_phase      = sam_pkg::PH_BACK;
                    n_zero_after = (r_phase == sam_pkg::PH_SEEK);
                    // An empty backoff ends on the limit item itself.
                    if (r_backoff == '0) begin
                        n_phase      = sam_pkg::PH_IDLE;
                        n_zero_after = 1'b0;
                        n_done       = 1'b1;
                        if (r_phase == sam_pkg::PH_SEEK) begin
                            n_pos = '0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= sam_pkg::PH_IDLE;
            r_pos        <= '0;
            r_steps_left <= '0;
            r_dir_neg    <= 1'b0;
            r_seq_idx    <= '0;
            r_elapsed    <= '0;
            r_zero_after <= 1'b0;
        end else if (w_adv) begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_steps_left <= n_steps_left;
            r_dir_neg    <= n_dir_neg;
            r_seq_idx    <= n_seq_idx;
            r_elapsed    <= n_elapsed;
            r_zero_after <= n_zero_after;
        end
    end

    // Result register: holds its transfer until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= r_in_vld;
        end
        if (w_adv) begin
            r_coils    <= (n_phase == sam_pkg::PH_IDLE) ? '0
                                                        : sam_pkg::coil_pattern(n_seq_idx);
            r_position <= n_pos;
            r_busy     <= (n_phase != sam_pkg::PH_IDLE);
            r_done     <= n_done;
        end
    end

    assign o_res.valid    = r_out_vld;
    assign o_res.coils    = r_coils;
    assign o_res.position = $signed(r_position);
    assign o_res.busy_res = r_busy;
    assign o_res.done_res = r_done;

    // A completed move or backoff always leaves the axis idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_done |-> !r_busy)
        else $error("done reported while the axis is still busy");

    // Coils are energized exactly when the reported state is busy.
    a_coils_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_busy == (r_coils != '0)))
        else $error("coil drive does not agree with busy");

    // A move or a backoff in progress always has steps remaining.
    a_steps_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == sam_pkg::PH_MOVE || r_phase == sam_pkg::PH_BACK) |-> r_steps_left != '0)
        else $error("stepping phase with no steps left");

endmodule
